>>> hdl/pld_pkg.sv
package pld_pkg;

  // Header digits per packet and the lengths they encode.
  localparam int HEADER_DIGITS = 4;
  localparam logic [1:0] LAST_DIGIT = 2'(HEADER_DIGITS - 1);
  localparam logic [15:0] LEN_FLUSH = 16'd0;
  localparam logic [15:0] LEN_DELIM = 16'd1;
  localparam logic [15:0] LEN_RESP_END = 16'd2;
  localparam logic [15:0] LEN_BAD = 16'd3;
  localparam logic [15:0] LEN_EMPTY = 16'(HEADER_DIGITS);

  // Section name that opens the pack section: "packfile\n".
  localparam logic [3:0] NAME_LEN = 4'd9;

  // Sideband channel codes.
  localparam logic [7:0] CHAN_PACK = 8'd1;
  localparam logic [7:0] CHAN_ERROR = 8'd3;
  localparam logic [1:0] CHAN_ERROR_ID = 2'd3;

  // Default depth of the queue between parser and output.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Input operations.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END = 1'b1;

  typedef enum logic [3:0] {
    ST_PACK = 4'd0,
    ST_PROGRESS = 4'd1,
    ST_SERVER_ERROR = 4'd2,
    ST_FLUSH = 4'd3,
    ST_END_NO_FLUSH = 4'd4,
    ST_BAD_HEX = 4'd5,
    ST_BAD_LENGTH = 4'd6,
    ST_UNKNOWN_CHAN = 4'd7,
    ST_TRUNCATED = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] byte_value;
    logic carries_byte;
    logic last_of_packet;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Hex digit decode: bit 4 set when the character is a valid digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Characters of the section name by position.
  function automatic logic [7:0] section_name(input logic [3:0] pos);
    logic [7:0] r;
    case (pos)
      4'd0: r = 8'h70;
      4'd1: r = 8'h61;
      4'd2: r = 8'h63;
      4'd3: r = 8'h6b;
      4'd4: r = 8'h66;
      4'd5: r = 8'h69;
      4'd6: r = 8'h6c;
      4'd7: r = 8'h65;
      4'd8: r = 8'h0a;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/pld_if.sv
interface pld_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface pld_out_if;
  logic valid;
  logic ready;
  logic [3:0] status;
  logic [7:0] byte_value;
  logic carries_byte;
  logic last_of_packet;

  modport source (output valid, output status, output byte_value, output carries_byte,
                  output last_of_packet, input ready);
  modport sink (input valid, input status, input byte_value, input carries_byte,
                input last_of_packet, output ready);
endinterface

>>> hdl/pkt_line_sideband_demux.sv
// Channel   Role     Handshake     Payload
// stream    sink     valid/ready   operation, data_byte
// result    source   valid/ready   status, byte_value, carries_byte, last_of_packet
//
// One request is accepted per cycle while the queue has room; the parser classifies it in that cycle.
// A result is registered in a queue of QUEUE_DEPTH entries and reaches the
// result channel from its head; the depth sets how long the output may stall
// before stream ready drops. Synchronous reset rst clears the parser and
// empties the queue; stream ready is low only while the queue is full.
module pkt_line_sideband_demux #(
  parameter int QUEUE_DEPTH = pld_pkg::QUEUE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  pld_in_if.sink stream,
  pld_out_if.source result
);
  import pld_pkg::*;

  logic push;
  result_t push_data;
  queue_stat_t q_stat;

  // Front: parser and classifier.
  pld_front u_front (
    .clk(clk),
    .rst(rst),
    .stream(stream),
    .space(!q_stat.full),
    .push(push),
    .push_data(push_data)
  );

  // Back: result queue and output channel.
  pld_back #(
    .DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .stat(q_stat),
    .result(result)
  );

  // Only defined status codes leave the block.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.status <= 4'(ST_TRUNCATED))
    else $error("undefined status code on result");

  // Payload bytes only travel with the three sideband statuses.
  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.carries_byte |-> result.status <= 4'(ST_SERVER_ERROR))
    else $error("payload byte with a non-sideband status");

  // End without flush never closes a packet.
  a_end_not_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == 4'(ST_END_NO_FLUSH) |-> !result.last_of_packet)
    else $error("end without flush marked as last of packet");

  // A result pushed into an empty queue shows on the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push && q_stat.empty |=> result.valid)
    else $error("queued result not presented");

endmodule

>>> hdl/pld_front.sv
module pld_front (
  input logic clk,
  input logic rst,
  pld_in_if.sink stream,
  input logic space,
  output logic push,
  output pld_pkg::result_t push_data
);
  import pld_pkg::*;

  phase_t parse_phase, parse_phase_next;
  logic [1:0] digit_count, digit_count_next;
  logic [15:0] length_acc, length_acc_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic in_pack_section, in_pack_section_next;
  logic [3:0] name_match_pos, name_match_pos_next;
  logic name_match_ok, name_match_ok_next;
  logic first_byte_pending, first_byte_pending_next;
  logic [1:0] active_channel, active_channel_next;

  logic accept;
  logic [4:0] hex;
  logic [15:0] len;
  logic [15:0] left_dec;
  logic last;
  logic [7:0] c;

  // A request is taken whenever the queue has room for its result.
  assign stream.ready = space;
  assign accept = stream.valid && space;
  assign c = stream.data_byte;
  assign hex = hex_value(c);
  assign len = {length_acc[11:0], hex[3:0]};
  assign left_dec = bytes_left - 16'd1;
  assign last = (left_dec == 16'd0);

  // Parser state update and result classification for one request.
  always_comb begin
    parse_phase_next = parse_phase;
    digit_count_next = digit_count;
    length_acc_next = length_acc;
    bytes_left_next = bytes_left;
    in_pack_section_next = in_pack_section;
    name_match_pos_next = name_match_pos;
    name_match_ok_next = name_match_ok;
    first_byte_pending_next = first_byte_pending;
    active_channel_next = active_channel;
    push = 1'b0;
    push_data = '0;

    if (stream.operation == OP_END) begin
      // End of stream reports its position unless parsing has stopped, then re-arms the parser.
      if (parse_phase == PH_HEADER && digit_count == 2'd0) begin
        push = accept;
        push_data.status = ST_END_NO_FLUSH;
      end else if (parse_phase == PH_HEADER || parse_phase == PH_PAYLOAD) begin
        push = accept;
        push_data.status = ST_TRUNCATED;
        push_data.last_of_packet = 1'b1;
      end
      parse_phase_next = PH_HEADER;
      digit_count_next = 2'd0;
      length_acc_next = 16'd0;
      bytes_left_next = 16'd0;
      in_pack_section_next = 1'b0;
      name_match_pos_next = 4'd0;
      name_match_ok_next = 1'b1;
      first_byte_pending_next = 1'b0;
      active_channel_next = 2'd0;
    end else begin
      case (parse_phase)
        PH_HEADER: begin
          if (!hex[4]) begin
            parse_phase_next = PH_STOP;
            push = accept;
            push_data.status = ST_BAD_HEX;
            push_data.last_of_packet = 1'b1;
          end else if (digit_count != LAST_DIGIT) begin
            length_acc_next = len;
            digit_count_next = digit_count + 2'd1;
          end else begin
            digit_count_next = 2'd0;
            length_acc_next = 16'd0;
            if (len == LEN_FLUSH) begin
              parse_phase_next = PH_STOP;
              push = accept;
              push_data.status = ST_FLUSH;
              push_data.last_of_packet = 1'b1;
            end else if (len == LEN_BAD) begin
              parse_phase_next = PH_STOP;
              push = accept;
              push_data.status = ST_BAD_LENGTH;
              push_data.last_of_packet = 1'b1;
            end else if (len != LEN_DELIM && len != LEN_RESP_END && len != LEN_EMPTY) begin
              bytes_left_next = len - LEN_EMPTY;
              parse_phase_next = PH_PAYLOAD;
              name_match_pos_next = 4'd0;
              name_match_ok_next = 1'b1;
              first_byte_pending_next = in_pack_section;
            end
          end
        end
        PH_PAYLOAD: begin
          bytes_left_next = left_dec;
          if (last) begin
            parse_phase_next = PH_HEADER;
          end
          if (!in_pack_section) begin
            // Match the section name; any extra byte spoils the match.
            if (name_match_pos >= NAME_LEN) begin
              name_match_ok_next = 1'b0;
            end else begin
              if (section_name(name_match_pos) != c) begin
                name_match_ok_next = 1'b0;
              end
              name_match_pos_next = name_match_pos + 4'd1;
            end
            if (last && name_match_ok_next && name_match_pos_next == NAME_LEN) begin
              in_pack_section_next = 1'b1;
            end
          end else if (first_byte_pending) begin
            // The first payload byte picks the sideband channel.
            first_byte_pending_next = 1'b0;
            if (c < CHAN_PACK || c > CHAN_ERROR) begin
              parse_phase_next = PH_STOP;
              push = accept;
              push_data.status = ST_UNKNOWN_CHAN;
              push_data.last_of_packet = 1'b1;
            end else begin
              active_channel_next = c[1:0];
              if (last && c == CHAN_ERROR) begin
                parse_phase_next = PH_STOP;
                push = accept;
                push_data.status = ST_SERVER_ERROR;
                push_data.last_of_packet = 1'b1;
              end
            end
          end else begin
            if (last && active_channel == CHAN_ERROR_ID) begin
              parse_phase_next = PH_STOP;
            end
            push = accept;
            push_data.status = {2'b00, active_channel - 2'd1};
            push_data.byte_value = c;
            push_data.carries_byte = 1'b1;
            push_data.last_of_packet = last;
          end
        end
        default: begin
          // Stopped: bytes are dropped until the end of the stream.
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_HEADER;
      digit_count <= 2'd0;
      length_acc <= 16'd0;
      bytes_left <= 16'd0;
      in_pack_section <= 1'b0;
      name_match_pos <= 4'd0;
      name_match_ok <= 1'b1;
      first_byte_pending <= 1'b0;
      active_channel <= 2'd0;
    end else if (accept) begin
      parse_phase <= parse_phase_next;
      digit_count <= digit_count_next;
      length_acc <= length_acc_next;
      bytes_left <= bytes_left_next;
      in_pack_section <= in_pack_section_next;
      name_match_pos <= name_match_pos_next;
      name_match_ok <= name_match_ok_next;
      first_byte_pending <= first_byte_pending_next;
      active_channel <= active_channel_next;
    end
  end

endmodule

>>> hdl/pld_back.sv
module pld_back #(
  parameter int DEPTH = pld_pkg::QUEUE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  input logic push,
  input pld_pkg::result_t push_data,
  output pld_pkg::queue_stat_t stat,
  pld_out_if.source result
);
  import pld_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  result_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic pop;
  result_t head;

  assign stat.full = (count == CNT_FULL);
  assign stat.empty = (count == '0);
  assign pop = result.valid && result.ready;

  // Head of the queue drives the result channel.
  assign head = entries[rd_ptr];
  assign result.valid = !stat.empty;
  assign result.status = head.status;
  assign result.byte_value = head.byte_value;
  assign result.carries_byte = head.carries_byte;
  assign result.last_of_packet = head.last_of_packet;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
